/* hdl/gacc_pkg.sv */
`default_nettype none

package gacc_pkg;

   localparam int unsigned HALF_W   = 64;
   localparam int unsigned BLOCK_W  = 2 * HALF_W;
   localparam int unsigned NIB_W    = 4;
   localparam int unsigned STEPS    = BLOCK_W / NIB_W;
   localparam int unsigned CNT_W    = $clog2(STEPS);
   localparam int unsigned REM_W    = 16;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [7:0] REDUCE_TOP = 8'he1;

   localparam logic [CSR_IDX_W-1:0] CSR_HASH_KEY_HIGH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_KEY_LOW  = 1'b1;

   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DONE
   } gacc_state_type;

   // reduction of the four bits shifted out of a 4-bit step
   function automatic logic [REM_W-1:0] rem_poly(input logic [NIB_W-1:0] nib);
      logic [REM_W-1:0] r;
      unique case (nib)
         4'h0: r = 16'h0000;
         4'h1: r = 16'h1c20;
         4'h2: r = 16'h3840;
         4'h3: r = 16'h2460;
         4'h4: r = 16'h7080;
         4'h5: r = 16'h6ca0;
         4'h6: r = 16'h48c0;
         4'h7: r = 16'h54e0;
         4'h8: r = 16'he100;
         4'h9: r = 16'hfd20;
         4'ha: r = 16'hd940;
         4'hb: r = 16'hc560;
         4'hc: r = 16'h9180;
         4'hd: r = 16'h8da0;
         4'he: r = 16'ha9c0;
         4'hf: r = 16'hb5e0;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/gacc_key_table.sv */
`default_nettype none

// H times a 4-bit value; the table is linear, so an entry is an XOR of H/x^k terms
module gacc_key_table
   import gacc_pkg::*;
(
   input  wire logic [HALF_W-1:0]  key_high,
   input  wire logic [HALF_W-1:0]  key_low,
   input  wire logic [NIB_W-1:0]   index,
   output logic      [BLOCK_W-1:0] entry
);

   logic [BLOCK_W-1:0] base [NIB_W];

   function automatic logic [BLOCK_W-1:0] shift_one(input logic [BLOCK_W-1:0] v);
      logic [BLOCK_W-1:0] r;
      r = v >> 1;
      if (v[0]) begin
         r[BLOCK_W-1 -: 8] = r[BLOCK_W-1 -: 8] ^ REDUCE_TOP;
      end
      return r;
   endfunction

   always_comb begin
      base[NIB_W-1] = {key_high, key_low};
      for (int k = NIB_W - 2; k >= 0; k--) begin
         base[k] = shift_one(base[k+1]);
      end
   end

   always_comb begin
      entry = '0;
      for (int k = 0; k < NIB_W; k++) begin
         if (index[k]) begin
            entry = entry ^ base[k];
         end
      end
   end

endmodule

`default_nettype wire

/* hdl/gacc_nibble_step.sv */
`default_nettype none

// one 4-bit multiply step: z >> 4, fold in the shifted-out nibble, add table entry
module gacc_nibble_step
   import gacc_pkg::*;
(
   input  wire logic [BLOCK_W-1:0] z_cur,
   input  wire logic [BLOCK_W-1:0] entry,
   output logic      [BLOCK_W-1:0] z_next
);

   logic [BLOCK_W-1:0] fold;

   always_comb begin
      fold = {rem_poly(z_cur[NIB_W-1:0]), {(BLOCK_W - REM_W){1'b0}}};
      z_next = (z_cur >> NIB_W) ^ fold ^ entry;
   end

endmodule

`default_nettype wire

/* hdl/ghash_accumulator_unit.sv */
// Absorb word: the nibble step unit folds in one nibble per step in ST_MUL, then ST_DONE loads the response.
// Clear word: the accumulator is zeroed on accept and ST_DONE loads the response.
// A new word is taken only in ST_IDLE, after the response of the last one is loaded, since the
// single shared nibble step unit serves one word at a time; a held response stalls ST_DONE.
// Configuration writes take effect on the next cycle; csr_ready is always high.
// Synchronous reset clears the accumulator, both key halves and all control state.
`default_nettype none

module ghash_accumulator_unit
   import gacc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [HALF_W-1:0]    csr_data,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_command,
   input  wire logic [HALF_W-1:0]    req_block_high,
   input  wire logic [HALF_W-1:0]    req_block_low,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [HALF_W-1:0]    rsp_hash_high,
   output logic      [HALF_W-1:0]    rsp_hash_low
);

   gacc_state_type      state_ff, state_in;
   logic [HALF_W-1:0]   key_high_ff, key_high_in;
   logic [HALF_W-1:0]   key_low_ff, key_low_in;
   logic [BLOCK_W-1:0]  acc_ff, acc_in;
   logic [BLOCK_W-1:0]  x_ff, x_in;
   logic [BLOCK_W-1:0]  z_ff, z_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]  rsp_ff, rsp_in;

   logic [BLOCK_W-1:0]  entry;
   logic [BLOCK_W-1:0]  z_next;
   logic                req_fire;
   logic                csr_fire;

   gacc_key_table u_key_table (
      .key_high (key_high_ff),
      .key_low  (key_low_ff),
      .index    (x_ff[NIB_W-1:0]),
      .entry    (entry)
   );

   gacc_nibble_step u_step (
      .z_cur  (z_ff),
      .entry  (entry),
      .z_next (z_next)
   );

   assign csr_ready     = 1'b1;
   assign csr_fire      = csr_valid && csr_ready;
   assign req_ready     = (state_ff == ST_IDLE);
   assign req_fire      = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hash_high = rsp_ff[BLOCK_W-1:HALF_W];
   assign rsp_hash_low  = rsp_ff[HALF_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_high_ff  <= '0;
         key_low_ff   <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_high_ff  <= key_high_in;
         key_low_ff   <= key_low_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      z_ff   <= z_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_HASH_KEY_HIGH: key_high_in = csr_data;
            CSR_HASH_KEY_LOW:  key_low_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      z_in         = z_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_command == CMD_CLEAR) begin
                  acc_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  x_in     = acc_ff ^ {req_block_high, req_block_low};
                  z_in     = '0;
                  cnt_in   = '0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            z_in   = z_next;
            x_in   = x_ff >> NIB_W;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               acc_in   = z_next;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_cnt_only_in_mul: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (state_ff == ST_MUL))
      else $error("step counter running outside multiply");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_command == CMD_CLEAR) |=> (acc_ff == '0))
      else $error("clear word did not zero accumulator");

   a_absorb_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_command == CMD_ABSORB) |=> (state_ff == ST_MUL && cnt_ff == '0))
      else $error("absorb word did not start multiply");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready))
      |=> (rsp_valid_ff && rsp_ff == $past(acc_ff)))
      else $error("response not loaded from accumulator");

endmodule

`default_nettype wire

/* test/tb_ghash_accumulator_unit.sv */
module tb_ghash_accumulator_unit;
   import gacc_pkg::*;

   localparam int MAX_GAP       = 10;
   localparam int LONG_HOLD     = 400;
   localparam int HOLD_AT       = 80;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_WORDS   = 86;
   localparam int PRINT_CAP     = 100;
   localparam logic [127:0] FOLD_POLY = {8'he1, 120'b0};

   class ghash_scoreboard;
      logic [127:0] hash_key;
      logic [127:0] accum;
      logic [127:0] key_mult[16];
      logic [15:0]  fold_tab[16];
      logic [127:0] hash_q[$];
      int errors;

      function new();
         fold_tab = '{16'h0000, 16'h1c20, 16'h3840, 16'h2460,
                      16'h7080, 16'h6ca0, 16'h48c0, 16'h54e0,
                      16'he100, 16'hfd20, 16'hd940, 16'hc560,
                      16'h9180, 16'h8da0, 16'ha9c0, 16'hb5e0};
         hash_key = '0;
         accum = '0;
         errors = 0;
         rebuild_table();
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
      endfunction

      // H times every nibble value
      function void rebuild_table();
         logic [127:0] v;
         v = hash_key;
         key_mult[0] = '0;
         key_mult[8] = v;
         for (int i = 4; i > 0; i = i >> 1) begin
            v = (v >> 1) ^ (v[0] ? FOLD_POLY : 128'b0);
            key_mult[i] = v;
         end
         for (int i = 2; i < 16; i = i << 1) begin
            for (int j = 1; j < i; j++)
               key_mult[i + j] = key_mult[i] ^ key_mult[j];
         end
      endfunction

      function void write_key(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
         if (idx == CSR_HASH_KEY_HIGH)
            hash_key[127:64] = data;
         else
            hash_key[63:0] = data;
         rebuild_table();
      endfunction

      function logic [127:0] times_h(logic [127:0] x);
         logic [127:0] z;
         logic [3:0]   low_nib;
         z = key_mult[x[3:0]];
         for (int n = 1; n < 32; n++) begin
            low_nib = z[3:0];
            z = z >> 4;
            z[127:112] = z[127:112] ^ fold_tab[low_nib];
            z = z ^ key_mult[x[4*n +: 4]];
         end
         return z;
      endfunction

      function void note_word(logic cmd, logic [63:0] hi, logic [63:0] lo);
         if (cmd == CMD_CLEAR)
            accum = '0;
         else
            accum = times_h(accum ^ {hi, lo});
         hash_q.push_back(accum);
      endfunction

      function void check_hash(logic [63:0] hi, logic [63:0] lo);
         logic [127:0] want;
         if (hash_q.size() == 0) begin
            report($sformatf("unexpected response %h_%h", hi, lo));
            return;
         end
         want = hash_q.pop_front();
         if (hi !== want[127:64])
            report($sformatf("hash_high got %h want %h", hi, want[127:64]));
         if (lo !== want[63:0])
            report($sformatf("hash_low got %h want %h", lo, want[63:0]));
      endfunction

      function int pending();
         return hash_q.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_HASH_KEY_HIGH;
   logic [HALF_W-1:0]    csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_command = CMD_ABSORB;
   logic [HALF_W-1:0]    req_block_high = '0;
   logic [HALF_W-1:0]    req_block_low = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [HALF_W-1:0]    rsp_hash_high;
   logic [HALF_W-1:0]    rsp_hash_low;

   int tx_gap_max = MAX_GAP;
   int rx_gap_max = MAX_GAP;
   int rsp_seen = 0;
   int cycle_count = 0;
   ghash_scoreboard sb = new();

   ghash_accumulator_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_block_high (req_block_high),
      .req_block_low  (req_block_low),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_high  (rsp_hash_high),
      .rsp_hash_low   (rsp_hash_low)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ghash_accumulator_unit verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_hash(rsp_hash_high, rsp_hash_low);
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_word(logic cmd, logic [63:0] hi, logic [63:0] lo);
      int gap;
      gap = $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_block_high <= hi;
      req_block_low <= lo;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_word(cmd, hi, lo);
   endtask

   // one long stall partway through fills the block and backs up the sender
   task automatic run_receiver();
      int gap;
      forever begin
         gap = (rsp_seen == HOLD_AT) ? LONG_HOLD : $urandom_range(0, rx_gap_max);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         rsp_seen++;
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_hash_key(logic [63:0] hi, logic [63:0] lo);
      csr_valid <= 1'b1;
      csr_index <= CSR_HASH_KEY_HIGH;
      csr_data <= hi;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      sb.write_key(CSR_HASH_KEY_HIGH, hi);
      csr_index <= CSR_HASH_KEY_LOW;
      csr_data <= lo;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      sb.write_key(CSR_HASH_KEY_LOW, lo);
      csr_valid <= 1'b0;
   endtask

   // mostly clear / data blocks / length block messages, some stray words
   task automatic random_phase(int quota);
      int sent;
      int blocks;
      int bytes;
      logic [127:0] blk;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(0, 9) < 2) begin
            send_word($urandom_range(0, 1) ? CMD_CLEAR : CMD_ABSORB, rand64(), rand64());
            sent++;
         end else begin
            send_word(CMD_CLEAR, rand64(), rand64());
            blocks = $urandom_range(1, 6);
            for (int b = 0; b < blocks; b++) begin
               blk = {rand64(), rand64()};
               if (b == blocks - 1 && $urandom_range(0, 1) == 1) begin
                  bytes = $urandom_range(1, 15);
                  blk = blk & (~128'b0 << (8 * (16 - bytes)));
               end
               send_word(CMD_ABSORB, blk[127:64], blk[63:0]);
            end
            send_word(CMD_ABSORB, 64'(8 * $urandom_range(0, 64)), 64'(128 * blocks));
            sent += blocks + 2;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      fork
         run_receiver();
      join_none

      set_hash_key(64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e);
      send_word(CMD_CLEAR, '1, '1);
      send_word(CMD_ABSORB, '0, '0);
      send_word(CMD_ABSORB, 64'h0388dace60b6a392, 64'hf328c2b971b2fe78);
      send_word(CMD_ABSORB, '0, 64'h80);
      send_word(CMD_ABSORB, '1, '1);
      send_word(CMD_ABSORB, 64'h8000000000000000, '0);
      send_word(CMD_ABSORB, '0, 64'h1);
      send_word(CMD_CLEAR, '0, '0);
      send_word(CMD_ABSORB, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
      settle();

      // key change keeps the accumulator
      set_hash_key('1, '1);
      send_word(CMD_ABSORB, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
      send_word(CMD_ABSORB, '1, '1);
      send_word(CMD_CLEAR, '1, '0);
      settle();

      set_hash_key(64'h8000000000000000, '0);
      send_word(CMD_ABSORB, 64'h0123456789abcdef, 64'hfedcba9876543210);
      send_word(CMD_ABSORB, '1, '1);
      settle();

      set_hash_key('0, '0);
      send_word(CMD_ABSORB, rand64(), rand64());
      send_word(CMD_ABSORB, '1, '1);
      settle();

      set_hash_key('0, 64'h1);
      send_word(CMD_CLEAR, '0, '1);
      send_word(CMD_ABSORB, 64'h8000000000000000, '0);
      send_word(CMD_ABSORB, '0, 64'h1);
      send_word(CMD_ABSORB, '1, '1);
      settle();

      for (int p = 0; p < 5; p++) begin
         tx_gap_max = (p == 1 || p == 3) ? 0 : MAX_GAP;
         rx_gap_max = (p == 2) ? 0 : MAX_GAP;
         case (p)
            1: set_hash_key('1, '1);
            3: set_hash_key(64'h8000000000000000, '0);
            default: set_hash_key(rand64(), rand64());
         endcase
         random_phase(PHASE_WORDS);
         settle();
      end

      if (sb.errors == 0)
         $display("ghash_accumulator_unit verification clean");
      else
         $display("ghash_accumulator_unit verification failed");
      $finish;
   end

endmodule
